FILE: src/rap_pkg.sv
// Shared types and constants for the router advertisement parser.
package rap_pkg;

    typedef enum logic [1:0] {
        STATUS_ACCEPT   = 2'd0,
        STATUS_NOT_RA   = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    typedef enum logic {
        CFG_OWN_HIGH = 1'b0,
        CFG_OWN_LOW  = 1'b1
    } cfg_index_t;

    localparam logic [7:0] RA_TYPE        = 8'd134;
    localparam logic [7:0] RA_CODE        = 8'd0;
    localparam logic [7:0] OPT_SRC_LL     = 8'd1;
    localparam logic [7:0] OPT_PREFIX     = 8'd3;
    localparam int         HDR_BYTES      = 16;
    localparam int         MIN_LAST_POS   = 15;
    localparam int         MAC_OPT_BYTES  = 8;
    localparam int         MAC_LAST_IDX   = 7;
    localparam int         PFX_SIZE_IDX   = 2;
    localparam int         PFX_FIRST_IDX  = 16;
    localparam int         PFX_LAST_IDX   = 31;
    localparam int         PFX_OPT_BYTES  = 32;
    localparam int         OPT_BYTES_W    = 11;
    localparam int         MAC_W          = 48;
    localparam int         ADDR_W         = 128;
    localparam logic [7:0] MAX_PFX_BITS   = 8'd128;

endpackage

FILE: src/router_advertisement_parser_top.sv
// Top level of the IPv6 router advertisement parser.
//
// Takes one ICMPv6 message byte per cycle, back to back, starting at the type
// byte; every byte passes an input register and one pass of parsing logic, and
// the last byte of a message loads the result register once that is free. A
// message yields exactly one item: status, router MAC and whether an option
// supplied that MAC. The input side stalls only while a finished item waits in
// the result register and the next last byte needs it. The user must write the
// own address through the configuration port only while idle (not enforced).
module router_advertisement_parser_top
    import rap_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // data_byte[7:0], sender_mac[55:8]
    input  logic        s_tlast,
    input  logic        s_tuser,   // header_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[1:0], adv_mac[49:2], zero[55:50]
    output logic        m_tuser    // mac_was_explicit
);

    localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int CW = (PW + 1 > OPT_BYTES_W) ? PW + 1 : OPT_BYTES_W;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_MESSAGE_BYTES);

    logic [63:0] own_high_reg;
    logic [63:0] own_low_reg;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic [MAC_W-1:0]      in_mac_reg;
    logic                  in_hok_reg;

    logic [PW-1:0]          pos_reg,       pos_next;
    logic [PW-1:0]          opt_start_reg, opt_start_next;
    logic [OPT_BYTES_W-1:0] opt_bytes_reg, opt_bytes_next;
    logic [7:0]             opt_kind_reg,  opt_kind_next;
    logic [7:0]             pfx_size_reg,  pfx_size_next;
    logic [63:0]            pfx_hi_reg,    pfx_hi_next;
    logic [63:0]            pfx_lo_reg,    pfx_lo_next;
    logic [MAC_W-1:0]       cap_mac_reg,   cap_mac_next;
    logic                   mac_found_reg, mac_found_next;
    logic                   pfx_match_reg, pfx_match_next;
    logic                   hdr_bad_reg,   hdr_bad_next;
    logic                   opt_stop_reg,  opt_stop_next;

    logic                  out_valid_reg;
    status_t               out_status_reg, out_status_next;
    logic [MAC_W-1:0]      out_mac_reg,    out_mac_next;
    logic                  out_expl_reg,   out_expl_next;

    logic                  out_free;
    logic                  proc_fire;
    logic                  short_msg;

    logic [PW-1:0]         idx;
    logic [CW-1:0]         idx_inc;
    logic [3:0]            pfx_k;
    logic [63:0]           byte_ins;
    logic                  decide;
    logic [7:0]            mask_bits;
    logic [ADDR_W-1:0]     pfx_mask;
    logic                  pfx_equal;

    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_comb begin
        pos_next       = pos_reg;
        opt_start_next = opt_start_reg;
        opt_bytes_next = opt_bytes_reg;
        opt_kind_next  = opt_kind_reg;
        pfx_size_next  = pfx_size_reg;
        pfx_hi_next    = pfx_hi_reg;
        pfx_lo_next    = pfx_lo_reg;
        cap_mac_next   = cap_mac_reg;
        mac_found_next = mac_found_reg;
        pfx_match_next = pfx_match_reg;
        hdr_bad_next   = hdr_bad_reg || !in_hok_reg;
        opt_stop_next  = opt_stop_reg;

        idx      = pos_reg - opt_start_reg;
        idx_inc  = CW'(idx) + CW'(1);
        pfx_k    = idx[3:0] - 4'(PFX_FIRST_IDX);
        byte_ins = {56'd0, in_byte_reg} << {~pfx_k[2:0], 3'b000};
        decide   = 1'b0;

        if (pos_reg < MAX_POS) begin
            if (pos_reg == PW'(0) && in_byte_reg != RA_TYPE) begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg == PW'(1) && in_byte_reg != RA_CODE) begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg >= PW'(HDR_BYTES) && !opt_stop_reg && pos_reg >= opt_start_reg) begin
                if (idx == PW'(0)) begin
                    opt_kind_next  = in_byte_reg;
                    opt_bytes_next = '0;
                    pfx_hi_next    = '0;
                    pfx_lo_next    = '0;
                end else if (idx == PW'(1)) begin
                    opt_bytes_next = {in_byte_reg, 3'b000};
                    if (in_byte_reg == 8'd0) begin
                        opt_stop_next = 1'b1;
                    end
                end else begin
                    if (opt_kind_reg == OPT_SRC_LL && idx <= PW'(MAC_LAST_IDX)) begin
                        pfx_hi_next = {16'd0, pfx_hi_reg[39:0], in_byte_reg};
                        if (idx == PW'(MAC_LAST_IDX) &&
                            opt_bytes_reg == OPT_BYTES_W'(MAC_OPT_BYTES)) begin
                            cap_mac_next   = pfx_hi_next[MAC_W-1:0];
                            mac_found_next = 1'b1;
                        end
                    end else if (opt_kind_reg == OPT_PREFIX) begin
                        if (idx == PW'(PFX_SIZE_IDX)) begin
                            pfx_size_next = in_byte_reg;
                        end
                        if (idx >= PW'(PFX_FIRST_IDX) && idx <= PW'(PFX_LAST_IDX)) begin
                            if (!pfx_k[3]) begin
                                pfx_hi_next = pfx_hi_reg | byte_ins;
                            end else begin
                                pfx_lo_next = pfx_lo_reg | byte_ins;
                            end
                        end
                        if (idx >= PW'(MAC_LAST_IDX)) begin
                            if (opt_bytes_reg >= OPT_BYTES_W'(PFX_OPT_BYTES)) begin
                                decide = (idx == PW'(PFX_LAST_IDX)) ||
                                         (in_last_reg && idx < PW'(PFX_LAST_IDX));
                            end else begin
                                decide = (idx == PW'(MAC_LAST_IDX));
                            end
                        end
                    end
                    if (idx_inc == CW'(opt_bytes_reg)) begin
                        opt_start_next = pos_reg + PW'(1);
                    end
                end
            end
            pos_next = pos_reg + PW'(1);
        end

        mask_bits = (pfx_size_reg > MAX_PFX_BITS) ? MAX_PFX_BITS : pfx_size_reg;
        pfx_mask  = ~({ADDR_W{1'b1}} >> mask_bits);
        pfx_equal = ((({own_high_reg, own_low_reg}) ^ {pfx_hi_next, pfx_lo_next})
                     & pfx_mask) == '0;
        if (decide) begin
            pfx_match_next = pfx_equal;
        end

        short_msg = (pos_reg < MAX_POS) && (pos_reg < PW'(MIN_LAST_POS));
        priority if (hdr_bad_next || short_msg) begin
            out_status_next = STATUS_NOT_RA;
        end else if (!pfx_match_next) begin
            out_status_next = STATUS_MISMATCH;
        end else begin
            out_status_next = STATUS_ACCEPT;
        end
        if (out_status_next != STATUS_NOT_RA && mac_found_next) begin
            out_mac_next  = cap_mac_next;
            out_expl_next = 1'b1;
        end else begin
            out_mac_next  = in_mac_reg;
            out_expl_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_high_reg <= '0;
            own_low_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OWN_HIGH: own_high_reg <= cfg_data;
                CFG_OWN_LOW:  own_low_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
            in_mac_reg  <= s_tdata[55:8];
            in_last_reg <= s_tlast;
            in_hok_reg  <= s_tuser;
        end
        if (proc_fire && in_last_reg) begin
            out_status_reg <= out_status_next;
            out_mac_reg    <= out_mac_next;
            out_expl_reg   <= out_expl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            opt_start_reg <= PW'(HDR_BYTES);
            opt_bytes_reg <= '0;
            opt_kind_reg  <= '0;
            pfx_size_reg  <= '0;
            pfx_hi_reg    <= '0;
            pfx_lo_reg    <= '0;
            cap_mac_reg   <= '0;
            mac_found_reg <= 1'b0;
            pfx_match_reg <= 1'b1;
            hdr_bad_reg   <= 1'b0;
            opt_stop_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                if (in_last_reg) begin
                    pos_reg       <= '0;
                    opt_start_reg <= PW'(HDR_BYTES);
                    opt_bytes_reg <= '0;
                    opt_kind_reg  <= '0;
                    pfx_size_reg  <= '0;
                    pfx_hi_reg    <= '0;
                    pfx_lo_reg    <= '0;
                    cap_mac_reg   <= '0;
                    mac_found_reg <= 1'b0;
                    pfx_match_reg <= 1'b1;
                    hdr_bad_reg   <= 1'b0;
                    opt_stop_reg  <= 1'b0;
                end else begin
                    pos_reg       <= pos_next;
                    opt_start_reg <= opt_start_next;
                    opt_bytes_reg <= opt_bytes_next;
                    opt_kind_reg  <= opt_kind_next;
                    pfx_size_reg  <= pfx_size_next;
                    pfx_hi_reg    <= pfx_hi_next;
                    pfx_lo_reg    <= pfx_lo_next;
                    cap_mac_reg   <= cap_mac_next;
                    mac_found_reg <= mac_found_next;
                    pfx_match_reg <= pfx_match_next;
                    hdr_bad_reg   <= hdr_bad_next;
                    opt_stop_reg  <= opt_stop_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_mac_reg, out_status_reg};
    assign m_tuser  = out_expl_reg;

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_POS)
        else $error("byte position past message limit");

    a_opt_start: assert property (@(posedge aclk) disable iff (!aresetn)
        opt_start_reg >= PW'(HDR_BYTES))
        else $error("option start inside fixed header");

    a_expl_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[1:0] != STATUS_NOT_RA)
        else $error("explicit MAC on rejected message");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] == STATUS_ACCEPT || m_tdata[1:0] == STATUS_NOT_RA ||
                     m_tdata[1:0] == STATUS_MISMATCH)
        else $error("undefined status code");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_last_reg |=> m_tvalid && pos_reg == '0)
        else $error("last byte did not produce an item");

endmodule

FILE: verif/ra_verdict_checker.sv
// Checker for the router advertisement parser: predicts each message verdict and compares it.
module ra_verdict_checker
    import rap_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // data_byte[7:0], sender_mac[55:8]
    input  logic        s_tlast,
    input  logic        s_tuser,   // header_ok
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // status[1:0], adv_mac[49:2], zero[55:50]
    input  logic        m_tuser,   // mac_was_explicit
    output int          mismatches,
    output int          verdicts_due
);

    localparam int UNIT_LAST_IDX = 7;

    typedef struct packed {
        status_t     status;
        logic [47:0] mac;
        logic        explicit_mac;
    } verdict_t;

    verdict_t    verdict_q[$];
    int          errors = 0;

    logic [63:0] own_high;
    logic [63:0] own_low;
    int          pos;
    int          opt_start;
    int          opt_len;
    logic [7:0]  opt_kind;
    logic [7:0]  pfx_bits;
    logic [63:0] pfx_word [2];
    logic [47:0] found_mac;
    logic        mac_seen;
    logic        pfx_ok;
    logic        hdr_bad;
    logic        opts_done;

    function automatic logic [63:0] top_mask(input int bits);
        if (bits <= 0) return '0;
        if (bits >= 64) return '1;
        return ~64'd0 << (64 - bits);
    endfunction

    task automatic clear_msg();
        pos         = 0;
        opt_start   = HDR_BYTES;
        opt_len     = 0;
        opt_kind    = '0;
        pfx_bits    = '0;
        pfx_word[0] = '0;
        pfx_word[1] = '0;
        found_mac   = '0;
        mac_seen    = 1'b0;
        pfx_ok      = 1'b1;
        hdr_bad     = 1'b0;
        opts_done   = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 50) begin
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        end
        errors++;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic lst, input logic [47:0] smac,
                              input logic hok);
        int       p;
        int       idx;
        int       n;
        logic     decide;
        verdict_t v;
        p = pos;
        if (!hok) hdr_bad = 1'b1;
        if (p < MAX_MESSAGE_BYTES) begin
            if (p == 0 && b != RA_TYPE) hdr_bad = 1'b1;
            if (p == 1 && b != RA_CODE) hdr_bad = 1'b1;
            if (p >= HDR_BYTES && !opts_done && p >= opt_start) begin
                idx = p - opt_start;
                if (idx == 0) begin
                    opt_kind    = b;
                    opt_len     = 0;
                    pfx_word[0] = '0;
                    pfx_word[1] = '0;
                end else if (idx == 1) begin
                    opt_len = int'(b) * 8;
                    if (opt_len == 0) opts_done = 1'b1;
                end else begin
                    if (opt_kind == OPT_SRC_LL && idx <= MAC_LAST_IDX) begin
                        pfx_word[0] = {16'd0, pfx_word[0][39:0], b};
                        if (idx == MAC_LAST_IDX && opt_len == MAC_OPT_BYTES) begin
                            found_mac = pfx_word[0][47:0];
                            mac_seen  = 1'b1;
                        end
                    end else if (opt_kind == OPT_PREFIX) begin
                        if (idx == PFX_SIZE_IDX) pfx_bits = b;
                        if (idx >= PFX_FIRST_IDX && idx <= PFX_LAST_IDX) begin
                            pfx_word[(idx - PFX_FIRST_IDX) / 8] |=
                                64'(b) << (8 * (7 - (idx - PFX_FIRST_IDX) % 8));
                        end
                        if (opt_len >= PFX_OPT_BYTES) begin
                            decide = (idx == PFX_LAST_IDX) ||
                                     (lst && idx < PFX_LAST_IDX && idx >= UNIT_LAST_IDX);
                        end else begin
                            decide = (idx == UNIT_LAST_IDX);
                        end
                        if (decide) begin
                            n = (pfx_bits > MAX_PFX_BITS) ? int'(MAX_PFX_BITS) : int'(pfx_bits);
                            pfx_ok = (((own_high ^ pfx_word[0]) & top_mask(n)) == '0) &&
                                     (((own_low ^ pfx_word[1]) & top_mask(n - 64)) == '0);
                        end
                    end
                    if (idx + 1 == opt_len) opt_start = p + 1;
                end
            end
            pos = p + 1;
        end
        if (lst) begin
            if (hdr_bad || (p < MAX_MESSAGE_BYTES && p < MIN_LAST_POS)) begin
                v.status = STATUS_NOT_RA;
            end else if (!pfx_ok) begin
                v.status = STATUS_MISMATCH;
            end else begin
                v.status = STATUS_ACCEPT;
            end
            if (v.status != STATUS_NOT_RA && mac_seen) begin
                v.mac          = found_mac;
                v.explicit_mac = 1'b1;
            end else begin
                v.mac          = smac;
                v.explicit_mac = 1'b0;
            end
            verdict_q.push_back(v);
            clear_msg();
        end
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            own_high = '0;
            own_low  = '0;
            verdict_q.delete();
            clear_msg();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_OWN_HIGH) begin
                    own_high = cfg_data;
                end else begin
                    own_low = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata[7:0], s_tlast, s_tdata[55:8], s_tuser);
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected item", 64'(m_tdata), '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[1:0] != want.status) begin
                        report_mismatch("status", 64'(m_tdata[1:0]), 64'(want.status));
                    end
                    if (m_tdata[49:2] != want.mac) begin
                        report_mismatch("adv_mac", 64'(m_tdata[49:2]), 64'(want.mac));
                    end
                    if (m_tuser != want.explicit_mac) begin
                        report_mismatch("mac_was_explicit", 64'(m_tuser), 64'(want.explicit_mac));
                    end
                end
            end
        end
        mismatches   <= errors;
        verdicts_due <= verdict_q.size();
    end

endmodule

FILE: verif/tb_router_advertisement_parser_top.sv
// Testbench top for the router advertisement parser: drives messages and gives the verdict.
module tb_router_advertisement_parser_top;
    import rap_pkg::*;

    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int QUIET_LIMIT       = 2000;
    localparam int LONG_HOLD         = 150;
    localparam int RANDOM_ITEMS      = 1600;
    localparam int PHASES            = 6;

    typedef enum int {
        HDR_GOOD,
        HDR_BAD_TYPE,
        HDR_BAD_CODE
    } hdr_kind_t;

    typedef enum int {
        SEG_MAC,
        SEG_MAC_WIDE,
        SEG_PREFIX,
        SEG_PREFIX_SHORT,
        SEG_ZERO_LEN,
        SEG_OTHER
    } seg_kind_t;

    typedef enum int {
        PFX_PICK,
        PFX_COPY,
        PFX_FLIP,
        PFX_NOISE
    } pfx_fill_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;

    int          mismatches;
    int          verdicts_due;
    int          quiet_cycles = 0;
    int          sent_items   = 0;
    logic        tx_idle      = 1'b0;
    logic        rx_idle      = 1'b0;
    logic        long_hold    = 1'b0;
    logic [63:0] own_high     = '0;
    logic [63:0] own_low      = '0;
    logic [7:0]  msg_q[$];

    router_advertisement_parser_top #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ra_verdict_checker #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .verdicts_due(verdicts_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("router_advertisement_parser_top: mismatch");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic start_msg(input hdr_kind_t hk);
        msg_q.delete();
        msg_q.push_back(hk == HDR_BAD_TYPE ? RA_TYPE ^ 8'($urandom_range(1, 255)) : RA_TYPE);
        msg_q.push_back(hk == HDR_BAD_CODE ? RA_CODE ^ 8'($urandom_range(1, 255)) : RA_CODE);
        repeat (HDR_BYTES - 2) msg_q.push_back(8'($urandom));
    endtask

    task automatic add_option(input seg_kind_t sk, input int plen_req = -1,
                              input pfx_fill_t fill = PFX_PICK);
        int           units;
        int           plen;
        int           n;
        int           flip;
        pfx_fill_t    how;
        logic [127:0] mask;
        logic [127:0] pfx;
        case (sk)
            SEG_MAC: begin
                msg_q.push_back(OPT_SRC_LL);
                msg_q.push_back(8'd1);
                repeat (6) msg_q.push_back(8'($urandom));
            end
            SEG_MAC_WIDE: begin
                msg_q.push_back(OPT_SRC_LL);
                msg_q.push_back(8'd2);
                repeat (14) msg_q.push_back(8'($urandom));
            end
            SEG_PREFIX: begin
                units = ($urandom_range(0, 3) == 0) ? 5 : 4;
                if (plen_req >= 0) begin
                    plen = plen_req;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       plen = 0;
                        1:       plen = 128;
                        2:       plen = $urandom_range(129, 255);
                        3:       plen = 64;
                        default: plen = $urandom_range(1, 127);
                    endcase
                end
                how = fill;
                if (how == PFX_PICK) begin
                    case ($urandom_range(0, 3))
                        0:       how = PFX_NOISE;
                        1:       how = PFX_FLIP;
                        default: how = PFX_COPY;
                    endcase
                end
                n    = (plen > 128) ? 128 : plen;
                mask = (n == 0) ? '0 : ~128'd0 << (128 - n);
                pfx  = ({own_high, own_low} & mask) | ({rand64(), rand64()} & ~mask);
                if (how == PFX_NOISE) begin
                    pfx = {rand64(), rand64()};
                end else if (how == PFX_FLIP && n > 0) begin
                    flip = 128 - $urandom_range(1, n);
                    pfx[flip] = ~pfx[flip];
                end
                msg_q.push_back(OPT_PREFIX);
                msg_q.push_back(8'(units));
                msg_q.push_back(8'(plen));
                repeat (PFX_FIRST_IDX - 3) msg_q.push_back(8'($urandom));
                for (int i = 15; i >= 0; i--) msg_q.push_back(pfx[i*8 +: 8]);
                repeat ((units - 4) * 8) msg_q.push_back(8'($urandom));
            end
            SEG_PREFIX_SHORT: begin
                units = $urandom_range(1, 3);
                msg_q.push_back(OPT_PREFIX);
                msg_q.push_back(8'(units));
                repeat (units * 8 - 2) msg_q.push_back(8'($urandom));
            end
            SEG_ZERO_LEN: begin
                msg_q.push_back(8'($urandom));
                msg_q.push_back(8'd0);
                repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom));
            end
            default: begin
                units = $urandom_range(1, 3);
                msg_q.push_back(8'($urandom));
                msg_q.push_back(8'(units));
                repeat (units * 8 - 2) msg_q.push_back(8'($urandom));
            end
        endcase
    endtask

    task automatic send_msg(input logic [47:0] mac, input int cut = 0, input int bad_at = -1);
        int n;
        n = (cut > 0 && cut < msg_q.size()) ? cut : msg_q.size();
        for (int i = 0; i < n; i++) begin
            if (tx_idle && $urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {mac, msg_q[i]};
            s_tlast  <= (i == n - 1);
            s_tuser  <= (i != bad_at);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sent_items++;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_own(input logic [63:0] hi, input logic [63:0] lo);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_OWN_HIGH;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_index <= CFG_OWN_LOW;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        own_high = hi;
        own_low  = lo;
    endtask

    initial begin
        int base;
        int pick;
        int cut;
        int bad_at;
        int k;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_OWN_HIGH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        start_msg(HDR_GOOD);
        send_msg('0);
        start_msg(HDR_GOOD);
        send_msg('1, MIN_LAST_POS);
        msg_q = '{RA_TYPE};
        send_msg(48'(rand64()));
        start_msg(HDR_BAD_TYPE);
        msg_q[0] = 8'hFF;
        add_option(SEG_MAC);
        send_msg(48'(rand64()));
        start_msg(HDR_BAD_CODE);
        add_option(SEG_MAC);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_MAC);
        send_msg(48'(rand64()), 0, 20);
        start_msg(HDR_GOOD);
        add_option(SEG_MAC);
        add_option(SEG_PREFIX, 128, PFX_COPY);
        send_msg(48'(rand64()));

        settle();
        write_own('1, '1);
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX, 0, PFX_NOISE);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX, 128, PFX_FLIP);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX, 200, PFX_COPY);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX_SHORT);
        send_msg(48'(rand64()));

        settle();
        write_own(rand64(), rand64());
        start_msg(HDR_GOOD);
        add_option(SEG_ZERO_LEN);
        add_option(SEG_MAC);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_MAC);
        send_msg(48'(rand64()), HDR_BYTES + 5);
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX, 64, PFX_COPY);
        send_msg(48'(rand64()), HDR_BYTES + 20);
        start_msg(HDR_GOOD);
        add_option(SEG_MAC_WIDE);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX, 96, PFX_COPY);
        add_option(SEG_PREFIX, 96, PFX_FLIP);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_PREFIX, 96, PFX_FLIP);
        add_option(SEG_PREFIX, 96, PFX_COPY);
        send_msg(48'(rand64()));
        start_msg(HDR_GOOD);
        add_option(SEG_MAC);
        add_option(SEG_PREFIX, 128, PFX_COPY);
        repeat (MAX_MESSAGE_BYTES + 1 - msg_q.size()) msg_q.push_back(8'($urandom));
        send_msg(48'(rand64()));

        base = sent_items;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       write_own('1, '0);
                2:       write_own('0, '1);
                default: write_own(rand64(), rand64());
            endcase
            if (ph == 2) long_hold = 1'b1;
            while (sent_items < base + (ph + 1) * RANDOM_ITEMS / PHASES) begin
                tx_idle = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
                rx_idle = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
                pick    = $urandom_range(0, 19);
                cut     = 0;
                bad_at  = -1;
                if (pick == 0) begin
                    msg_q.delete();
                    repeat ($urandom_range(1, 40)) msg_q.push_back(8'($urandom));
                end else begin
                    start_msg(pick == 1 ? HDR_BAD_TYPE : pick == 2 ? HDR_BAD_CODE : HDR_GOOD);
                    repeat ($urandom_range(0, 3)) begin
                        k = $urandom_range(0, 11);
                        add_option(k < 3 ? SEG_MAC : k < 4 ? SEG_MAC_WIDE :
                                   k < 8 ? SEG_PREFIX : k < 9 ? SEG_PREFIX_SHORT :
                                   k < 10 ? SEG_ZERO_LEN : SEG_OTHER);
                    end
                    if (pick == 3) begin
                        cut = $urandom_range(1, HDR_BYTES);
                    end else if (pick == 4 || $urandom_range(0, 5) == 0) begin
                        cut = $urandom_range(HDR_BYTES + 1, msg_q.size());
                    end else if (pick == 5) begin
                        bad_at = $urandom_range(0, msg_q.size() - 1);
                    end
                end
                send_msg(48'(rand64()), cut, bad_at);
            end
        end

        settle();
        repeat (6) @(posedge aclk);
        if (mismatches == 0) begin
            $display("router_advertisement_parser_top: match");
        end else begin
            $display("router_advertisement_parser_top: mismatch");
        end
        $finish;
    end

endmodule
